### sv/websocket_frame_deframer_core_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define WSDF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, checked out of reset.
`define WSDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

### sv/wsdf_pkg.sv
// Types and constants of the WebSocket frame deframer.
package wsdf_pkg;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ACT_DELIVER  = 2'd0;
    localparam logic [1:0] ACT_PONG     = 2'd1;
    localparam logic [1:0] ACT_CLOSE    = 2'd2;

    localparam logic [3:0] OP_CLOSE     = 4'd8;
    localparam logic [3:0] OP_PING      = 4'd9;

    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam logic [3:0] EXT16_BYTES  = 4'd2;
    localparam logic [3:0] EXT64_BYTES  = 4'd8;

    localparam logic [2:0] PH_HDR0      = 3'd0;
    localparam logic [2:0] PH_HDR1      = 3'd1;
    localparam logic [2:0] PH_EXT       = 3'd2;
    localparam logic [2:0] PH_KEY       = 3'd3;
    localparam logic [2:0] PH_PAY       = 3'd4;

    // One classified item passed from the parser to the result stage.
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] opcode;
        logic       fin;
        logic [7:0] data;
        logic [7:0] key;
        logic       last;
    } t_cmd;

endpackage

### sv/wsdf_front.sv
// Header parser: tracks the frame phase and classifies each received item.
module wsdf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_rx_byte,
    output logic               o_cmd_valid,
    output wsdf_pkg::t_cmd     o_cmd
);

    logic [2:0]  r_phase,     n_phase;
    logic [3:0]  r_ext_count, n_ext_count;
    logic [3:0]  r_opcode,    n_opcode;
    logic        r_fin,       n_fin;
    logic [63:0] r_remaining, n_remaining;
    logic [31:0] r_mask_key,  n_mask_key;
    logic [1:0]  r_key_index, n_key_index;
    logic        r_closed,    n_closed;

    logic [7:0]  key_byte;
    logic        rem_one;

    always_comb begin
        unique case (r_key_index)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end

    assign rem_one = (r_remaining == 64'd1);

    always_comb begin
        n_phase     = r_phase;
        n_ext_count = r_ext_count;
        n_opcode    = r_opcode;
        n_fin       = r_fin;
        n_remaining = r_remaining;
        n_mask_key  = r_mask_key;
        n_key_index = r_key_index;
        n_closed    = r_closed;
        o_cmd_valid = 1'b0;
        o_cmd.kind   = wsdf_pkg::KIND_PAYLOAD;
        o_cmd.opcode = r_opcode;
        o_cmd.fin    = r_fin;
        o_cmd.data   = 8'd0;
        o_cmd.key    = 8'd0;
        o_cmd.last   = 1'b1;
        if (i_accept && !r_closed) begin
            unique case (r_phase)
                wsdf_pkg::PH_HDR0: begin
                    n_fin   = i_rx_byte[7];
                    n_opcode = i_rx_byte[3:0];
                    n_phase = wsdf_pkg::PH_HDR1;
                end
                wsdf_pkg::PH_HDR1: begin
                    if (!i_rx_byte[7]) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = wsdf_pkg::KIND_ERROR;
                        n_closed    = 1'b1;
                        n_phase     = wsdf_pkg::PH_HDR0;
                    end else begin
                        n_key_index = 2'd0;
                        n_mask_key  = 32'd0;
                        if (i_rx_byte[6:0] == wsdf_pkg::LEN_EXT16) begin
                            n_remaining = 64'd0;
                            n_ext_count = wsdf_pkg::EXT16_BYTES;
                            n_phase     = wsdf_pkg::PH_EXT;
                        end else if (i_rx_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
                            n_remaining = 64'd0;
                            n_ext_count = wsdf_pkg::EXT64_BYTES;
                            n_phase     = wsdf_pkg::PH_EXT;
                        end else begin
                            n_remaining = {57'd0, i_rx_byte[6:0]};
                            n_ext_count = 4'd0;
                            n_phase     = wsdf_pkg::PH_KEY;
                        end
                    end
                end
                wsdf_pkg::PH_EXT: begin
                    n_remaining = {r_remaining[55:0], i_rx_byte};
                    n_ext_count = r_ext_count - 4'd1;
                    if (r_ext_count == 4'd1) begin
                        n_phase = wsdf_pkg::PH_KEY;
                    end
                end
                wsdf_pkg::PH_KEY: begin
                    n_mask_key  = {r_mask_key[23:0], i_rx_byte};
                    n_key_index = r_key_index + 2'd1;
                    if (r_key_index == 2'd3) begin
                        if (r_opcode == wsdf_pkg::OP_CLOSE) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = wsdf_pkg::KIND_EMPTY;
                            n_closed    = 1'b1;
                            n_phase     = wsdf_pkg::PH_HDR0;
                        end else if (r_remaining == 64'd0) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = wsdf_pkg::KIND_EMPTY;
                            n_phase     = wsdf_pkg::PH_HDR0;
                        end else begin
                            n_phase = wsdf_pkg::PH_PAY;
                        end
                    end
                end
                wsdf_pkg::PH_PAY: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = wsdf_pkg::KIND_PAYLOAD;
                    o_cmd.data  = i_rx_byte;
                    o_cmd.key   = key_byte;
                    o_cmd.last  = rem_one;
                    n_remaining = r_remaining - 64'd1;
                    n_key_index = r_key_index + 2'd1;
                    if (rem_one) begin
                        n_key_index = 2'd0;
                        n_phase     = wsdf_pkg::PH_HDR0;
                    end
                end
                default: begin
                    n_phase = wsdf_pkg::PH_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= wsdf_pkg::PH_HDR0;
            r_ext_count <= 4'd0;
            r_opcode    <= 4'd0;
            r_fin       <= 1'b0;
            r_remaining <= 64'd0;
            r_mask_key  <= 32'd0;
            r_key_index <= 2'd0;
            r_closed    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_ext_count <= n_ext_count;
            r_opcode    <= n_opcode;
            r_fin       <= n_fin;
            r_remaining <= n_remaining;
            r_mask_key  <= n_mask_key;
            r_key_index <= n_key_index;
            r_closed    <= n_closed;
        end
    end

endmodule

### sv/wsdf_fifo.sv
// Short queue of classified items between the parser and the result stage.
module wsdf_fifo #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  wsdf_pkg::t_cmd     i_wr_cmd,
    input  logic               i_rd,
    output wsdf_pkg::t_cmd     o_rd_cmd,
    output logic               o_full,
    output logic               o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    wsdf_pkg::t_cmd  r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            do_wr, do_rd;

    assign o_full   = (r_count == FULL_CNT);
    assign o_empty  = (r_count == '0);
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && !o_empty;
    assign o_rd_cmd = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CW'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### sv/wsdf_back.sv
// Result stage: unmasks payload and picks the action for the queued item.
module wsdf_back (
    input  wsdf_pkg::t_cmd i_cmd,
    output logic [1:0]     o_kind,
    output logic [1:0]     o_action,
    output logic [3:0]     o_opcode,
    output logic           o_fin,
    output logic [7:0]     o_payload_byte,
    output logic           o_last
);

    always_comb begin
        if (i_cmd.kind == wsdf_pkg::KIND_ERROR) begin
            o_action = wsdf_pkg::ACT_CLOSE;
        end else if (i_cmd.opcode == wsdf_pkg::OP_PING) begin
            o_action = wsdf_pkg::ACT_PONG;
        end else if (i_cmd.opcode == wsdf_pkg::OP_CLOSE) begin
            o_action = wsdf_pkg::ACT_CLOSE;
        end else begin
            o_action = wsdf_pkg::ACT_DELIVER;
        end
    end

    assign o_kind         = i_cmd.kind;
    assign o_opcode       = i_cmd.opcode;
    assign o_fin          = i_cmd.fin;
    assign o_last         = i_cmd.last;
    assign o_payload_byte = (i_cmd.kind == wsdf_pkg::KIND_PAYLOAD) ?
                            (i_cmd.data ^ i_cmd.key) : 8'd0;

endmodule

### sv/websocket_frame_deframer_core.sv
// Top level of the WebSocket receive-side frame deframer.
// This block takes a received WebSocket byte stream, one byte per item, and
// turns it into results: unmasked payload bytes with the last byte of each
// frame marked, one empty-frame result for a zero-length frame, and one close
// result for a close frame or an unmasked frame, after which every further
// byte is discarded until reset. Frames may follow one another without gaps;
// extended lengths are read big-endian. A byte is taken in every cycle in which
// push is high and full is low, so the block sustains one item per clock; full
// rises only when the queue between the header parser and the result stage
// holds FIFO_DEPTH results that the consumer has not popped. Each result is queued
// as its byte is accepted and reaches the outputs once all older ones are popped.
`include "websocket_frame_deframer_core_defines.svh"

module websocket_frame_deframer_core #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [1:0] o_action,
    output logic [3:0] o_opcode,
    output logic       o_fin,
    output logic [7:0] o_payload_byte,
    output logic       o_last
);

    // A byte is accepted whenever the queue has room, whether or not it
    // produces a result; this keeps the accept rule simple for the sender.
    logic           accept;
    logic           cmd_valid;
    wsdf_pkg::t_cmd cmd_in;
    wsdf_pkg::t_cmd cmd_out;

    assign accept = push && !full;

    // Front: header parsing, length and key capture, classification.
    wsdf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_in)
    );

    // Queue: decouples the parser from a consumer that stalls.
    wsdf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cmd_valid),
        .i_wr_cmd (cmd_in),
        .i_rd     (pop),
        .o_rd_cmd (cmd_out),
        .o_full   (full),
        .o_empty  (empty)
    );

    // Back: unmasking and action selection on the oldest queued item.
    wsdf_back u_back (
        .i_cmd          (cmd_out),
        .o_kind         (o_kind),
        .o_action       (o_action),
        .o_opcode       (o_opcode),
        .o_fin          (o_fin),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last)
    );

    // The queue cannot be full and empty at once.
    `WSDF_ASSERT_NOW(a_full_empty, full, !empty)
    // A protocol error always closes and ends the frame.
    `WSDF_ASSERT_NOW(a_err_close, !empty && (o_kind == wsdf_pkg::KIND_ERROR),
        (o_action == wsdf_pkg::ACT_CLOSE) && o_last)
    // Only payload results carry a data byte.
    `WSDF_ASSERT_NOW(a_zero_data, !empty && (o_kind != wsdf_pkg::KIND_PAYLOAD),
        (o_payload_byte == 8'd0) && o_last)
    // An accepted byte never leaves the queue empty with nothing taken out
    // when it produced a result.
    `WSDF_ASSERT_NEXT(a_result_shows, cmd_valid && !pop, !empty)

endmodule

### bench/websocket_frame_deframer_core_checker.sv
// Checker for the WebSocket deframer: watches both handshakes, predicts each result and compares.
module websocket_frame_deframer_core_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_rx_byte,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [1:0] i_kind,
    input  logic [1:0] i_action,
    input  logic [3:0] i_opcode,
    input  logic       i_fin,
    input  logic [7:0] i_payload_byte,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] action;
        logic [3:0] opcode;
        logic       fin;
        logic [7:0] data;
        logic       last;
    } t_deframed;

    t_deframed   results_due[$];
    int          mismatch_count = 0;

    // Predicted parser state.
    logic [2:0]  parse_phase;
    logic [3:0]  ext_left;
    logic [3:0]  hdr_opcode;
    logic        hdr_fin;
    logic [63:0] bytes_left;
    logic [31:0] mask_word;
    logic [1:0]  key_pos;
    logic        link_closed;

    function automatic logic [1:0] action_for(input logic [3:0] op);
        if (op == wsdf_pkg::OP_PING) return wsdf_pkg::ACT_PONG;
        if (op == wsdf_pkg::OP_CLOSE) return wsdf_pkg::ACT_CLOSE;
        return wsdf_pkg::ACT_DELIVER;
    endfunction

    task automatic queue_result(input logic [1:0] kind, input logic [1:0] action,
                                input logic [7:0] data, input logic last);
        t_deframed r;
        r.kind   = kind;
        r.action = action;
        r.opcode = hdr_opcode;
        r.fin    = hdr_fin;
        r.data   = data;
        r.last   = last;
        results_due.push_back(r);
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] k;
        if (link_closed) return;
        case (parse_phase)
            wsdf_pkg::PH_HDR0: begin
                hdr_fin     = b[7];
                hdr_opcode  = b[3:0];
                parse_phase = wsdf_pkg::PH_HDR1;
            end
            wsdf_pkg::PH_HDR1: begin
                if (!b[7]) begin
                    // An unmasked frame from the client is a protocol error.
                    queue_result(wsdf_pkg::KIND_ERROR, wsdf_pkg::ACT_CLOSE, 8'h00, 1'b1);
                    link_closed = 1'b1;
                    parse_phase = wsdf_pkg::PH_HDR0;
                end else begin
                    bytes_left = '0;
                    key_pos    = '0;
                    mask_word  = '0;
                    if (b[6:0] == wsdf_pkg::LEN_EXT16) begin
                        ext_left    = wsdf_pkg::EXT16_BYTES;
                        parse_phase = wsdf_pkg::PH_EXT;
                    end else if (b[6:0] == wsdf_pkg::LEN_EXT64) begin
                        ext_left    = wsdf_pkg::EXT64_BYTES;
                        parse_phase = wsdf_pkg::PH_EXT;
                    end else begin
                        bytes_left  = 64'(b[6:0]);
                        ext_left    = '0;
                        parse_phase = wsdf_pkg::PH_KEY;
                    end
                end
            end
            wsdf_pkg::PH_EXT: begin
                bytes_left = {bytes_left[55:0], b};
                ext_left   = ext_left - 4'd1;
                if (ext_left == 4'd0) parse_phase = wsdf_pkg::PH_KEY;
            end
            wsdf_pkg::PH_KEY: begin
                mask_word = {mask_word[23:0], b};
                key_pos   = key_pos + 2'd1;
                if (key_pos == 2'd0) begin
                    if (hdr_opcode == wsdf_pkg::OP_CLOSE) begin
                        queue_result(wsdf_pkg::KIND_EMPTY, wsdf_pkg::ACT_CLOSE, 8'h00, 1'b1);
                        link_closed = 1'b1;
                        parse_phase = wsdf_pkg::PH_HDR0;
                    end else if (bytes_left == 64'd0) begin
                        queue_result(wsdf_pkg::KIND_EMPTY, action_for(hdr_opcode),
                                     8'h00, 1'b1);
                        parse_phase = wsdf_pkg::PH_HDR0;
                    end else begin
                        parse_phase = wsdf_pkg::PH_PAY;
                    end
                end
            end
            wsdf_pkg::PH_PAY: begin
                k          = mask_word[8 * (3 - int'(key_pos)) +: 8];
                key_pos    = key_pos + 2'd1;
                bytes_left = bytes_left - 64'd1;
                queue_result(wsdf_pkg::KIND_PAYLOAD, action_for(hdr_opcode), b ^ k,
                             bytes_left == 64'd0);
                if (bytes_left == 64'd0) begin
                    key_pos     = '0;
                    parse_phase = wsdf_pkg::PH_HDR0;
                end
            end
            default: parse_phase = wsdf_pkg::PH_HDR0;
        endcase
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_deframed want;
        if (!i_rst_n) begin
            parse_phase = wsdf_pkg::PH_HDR0;
            ext_left    = '0;
            hdr_opcode  = '0;
            hdr_fin     = 1'b0;
            bytes_left  = '0;
            mask_word   = '0;
            key_pos     = '0;
            link_closed = 1'b0;
            results_due.delete();
        end else begin
            // A result becomes visible only after its byte, so compare before predicting.
            if (i_pop && !i_empty) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result mismatch, expected none, actual kind %0h data %0h",
                             $time, i_kind, i_payload_byte);
                    mismatch_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("kind", 8'(want.kind), 8'(i_kind));
                    check_field("action", 8'(want.action), 8'(i_action));
                    check_field("opcode", 8'(want.opcode), 8'(i_opcode));
                    check_field("fin", 8'(want.fin), 8'(i_fin));
                    check_field("payload_byte", want.data, i_payload_byte);
                    check_field("last", 8'(want.last), 8'(i_last));
                end
            end
            if (i_push && !i_full) deframe_byte(i_rx_byte);
        end
        o_fail_count  <= mismatch_count;
        o_outstanding <= results_due.size();
    end

endmodule

### bench/websocket_frame_deframer_core_tb.sv
// Top of the deframer testbench: clock, reset, frame stimulus, result draining and verdict.
module websocket_frame_deframer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // How the payload length of a frame is encoded in its header.
    typedef enum int {LEN_SHORT, LEN_WIDE16, LEN_WIDE64} t_len_form;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [1:0] o_kind;
    logic [1:0] o_action;
    logic [3:0] o_opcode;
    logic       o_fin;
    logic [7:0] o_payload_byte;
    logic       o_last;

    int fail_count;
    int outstanding;

    // Number of items taken by the block so far.
    int bytes_offered = 0;
    // While set, neither the sender nor the receiver idles.
    bit steady = 1'b0;
    // Cycles for which the receiver still has to hold off; counted down by the receiver.
    int hold_off_left = 0;

    always #10 i_clk = ~i_clk;

    websocket_frame_deframer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_action       (o_action),
        .o_opcode       (o_opcode),
        .o_fin          (o_fin),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last)
    );

    websocket_frame_deframer_core_checker deframe_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_rx_byte      (i_rx_byte),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_kind         (o_kind),
        .i_action       (o_action),
        .i_opcode       (o_opcode),
        .i_fin          (o_fin),
        .i_payload_byte (o_payload_byte),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    // Offers one byte to the block, after a random number of idle cycles, and returns at the
    // edge at which it is accepted. The byte and push are held while full is high. The full
    // flag is read straight after the edge, so it is the value the block saw at that edge.
    task automatic offer_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 34) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_offered++;
    endtask

    // Sends one masked frame: header, length in the requested form, masking key and, unless
    // it is a close frame, a payload of random bytes. The length field is sent big-endian.
    task automatic send_frame(input logic [3:0] op, input logic fin_bit, input logic [2:0] rsv,
                              input t_len_form form, input logic [63:0] len,
                              input logic [31:0] key);
        longint unsigned n;
        offer_byte({fin_bit, rsv, op});
        case (form)
            LEN_SHORT: begin
                offer_byte({1'b1, len[6:0]});
            end
            LEN_WIDE16: begin
                offer_byte({1'b1, wsdf_pkg::LEN_EXT16});
                offer_byte(len[15:8]);
                offer_byte(len[7:0]);
            end
            default: begin
                offer_byte({1'b1, wsdf_pkg::LEN_EXT64});
                for (n = 0; n < 8; n++) offer_byte(len[63 - 8 * n -: 8]);
            end
        endcase
        for (n = 0; n < 4; n++) offer_byte(key[31 - 8 * n -: 8]);
        // The payload of a close frame is never delivered, and the block ignores it anyway.
        if (op != wsdf_pkg::OP_CLOSE) begin
            for (n = 0; n < len; n++) offer_byte(8'($urandom));
        end
    endtask

    // Receiver: pops at random, never during a hold-off, always during a steady stretch.
    // Popping while empty moves nothing, so pop need not follow empty.
    initial begin
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (hold_off_left > 0) begin
                pop <= 1'b0;
                hold_off_left--;
            end else begin
                pop <= steady || ($urandom_range(99) >= 34);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int          frame_no;
        int          pick;
        logic [3:0]  op;
        t_len_form   form;
        logic [63:0] len;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A text frame with an all-zero key, so that the extreme byte values
        // come out unchanged and the last of the two is marked.
        offer_byte({1'b1, 3'b000, 4'h1});
        offer_byte({1'b1, 7'd2});
        repeat (4) offer_byte(8'h00);
        offer_byte(8'h00);
        offer_byte(8'hFF);
        // An empty ping with every reserved bit set, fin clear and an all-ones key: one
        // empty-frame result that asks for a pong.
        send_frame(wsdf_pkg::OP_PING, 1'b0, 3'b111, LEN_SHORT, 64'd0, 32'hFFFF_FFFF);
        // A zero length sent in the 16-bit extended form is still an empty frame.
        send_frame(4'h0, 1'b1, 3'b000, LEN_WIDE16, 64'd0, $urandom);

        // Random part: well-formed masked frames back to back, mostly short, some with
        // extended lengths (non-minimal encodings included), any opcode but close.
        frame_no = 0;
        while (bytes_offered < 1100) begin
            steady = (frame_no >= 20 && frame_no < 40);
            op = 4'($urandom);
            while (op == wsdf_pkg::OP_CLOSE) op = 4'($urandom);
            pick = $urandom_range(99);
            if (pick < 70) begin
                form = LEN_SHORT;
                len  = ($urandom_range(9) == 0) ? 64'($urandom_range(125))
                                                : 64'($urandom_range(12));
            end else if (pick < 85) begin
                form = LEN_WIDE16;
                len  = ($urandom_range(7) == 0) ? 64'($urandom_range(300))
                                                : 64'($urandom_range(16));
            end else begin
                form = LEN_WIDE64;
                len  = 64'($urandom_range(16));
            end
            // One long frame while the receiver holds off, so that the result queue fills
            // and the block has to refuse bytes for a while.
            if (frame_no == 6) begin
                hold_off_left = 80;
                form          = LEN_SHORT;
                len           = 64'd60;
            end
            send_frame(op, 1'($urandom), 3'($urandom), form, len, $urandom);
            frame_no++;
        end
        steady = 1'b0;

        // The connection can be closed only once per run, so the seed chooses how: a close
        // frame whose 64-bit length has its top bit set, or a frame without the mask bit.
        if ($urandom_range(1) == 1) begin
            len     = {$urandom, $urandom};
            len[63] = 1'b1;
            send_frame(wsdf_pkg::OP_CLOSE, 1'($urandom), 3'($urandom), LEN_WIDE64, len,
                       $urandom);
        end else begin
            offer_byte(8'($urandom));
            offer_byte({1'b0, 7'($urandom)});
        end
        // Once closed, everything is discarded and no further result may appear.
        repeat (6) offer_byte(8'($urandom));
        push <= 1'b0;

        // Drain, then give the block a few more cycles to show any stray result.
        while (outstanding != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
